/* rtl/core/lbcd_pkg.sv */
// Shared types and constants for the LRU block cache directory.
package lbcd_pkg;

    localparam int CACHE_SLOTS_DEF = 64;
    localparam int FILE_W          = 16;
    localparam int BLOCK_W         = 31;
    localparam int TAG_W           = FILE_W + BLOCK_W;
    localparam int STATUS_W        = 2;
    localparam int SLOT_OUT_W      = 6;

    // Result codes carried on the status port
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT  = 2'd0,
        ST_FILL = 2'd1,
        ST_ERR  = 2'd2
    } status_code_t;

    // Controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_LRD,
        S_LK1,
        S_LK2,
        S_LK3,
        S_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic         init_wr;
        logic         load_req;
        logic         scan_issue;
        logic         set_res;
        status_code_t res_code;
        logic         fill_wr;
        logic         link_rd;
        logic         link_step1;
        logic         link_step2;
        logic         link_step3;
        logic         out_load;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic init_last;
        logic hit;
        logic more;
        logic fetch_ok;
        logic is_newest;
        logic out_busy;
    } dp_sts_t;

endpackage

/* rtl/core/lbcd_ctrl.sv */
// Sequencer for lookup, fill and recency list update.
module lbcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lbcd_pkg::dp_sts_t sts,
    output lbcd_pkg::dp_cmd_t cmd
);

    lbcd_pkg::state_t state_reg;
    lbcd_pkg::state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbcd_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbcd_pkg::S_INIT:
            begin
                if (sts.init_last)
                begin
                    state_next = lbcd_pkg::S_IDLE;
                end
            end
            lbcd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lbcd_pkg::S_SCAN;
                end
            end
            lbcd_pkg::S_SCAN:
            begin
                if (sts.hit)
                begin
                    state_next = lbcd_pkg::S_LRD;
                end
                else if (!sts.more)
                begin
                    state_next = sts.fetch_ok ? lbcd_pkg::S_FILL : lbcd_pkg::S_DONE;
                end
            end
            lbcd_pkg::S_FILL:
            begin
                state_next = lbcd_pkg::S_LRD;
            end
            lbcd_pkg::S_LRD:
            begin
                state_next = sts.is_newest ? lbcd_pkg::S_DONE : lbcd_pkg::S_LK1;
            end
            lbcd_pkg::S_LK1:
            begin
                state_next = lbcd_pkg::S_LK2;
            end
            lbcd_pkg::S_LK2:
            begin
                state_next = lbcd_pkg::S_LK3;
            end
            lbcd_pkg::S_LK3:
            begin
                state_next = lbcd_pkg::S_DONE;
            end
            lbcd_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = lbcd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lbcd_pkg::S_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd          = '0;
        cmd.res_code = lbcd_pkg::ST_HIT;
        in_stall     = 1'b1;
        case (state_reg)
            lbcd_pkg::S_INIT:
            begin
                cmd.init_wr = 1'b1;
            end
            lbcd_pkg::S_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load_req = in_valid;
            end
            lbcd_pkg::S_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = lbcd_pkg::ST_HIT;
                end
                else if (sts.more)
                begin
                    cmd.scan_issue = 1'b1;
                end
                else
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = sts.fetch_ok ? lbcd_pkg::ST_FILL : lbcd_pkg::ST_ERR;
                end
            end
            lbcd_pkg::S_FILL:
            begin
                cmd.fill_wr = 1'b1;
            end
            lbcd_pkg::S_LRD:
            begin
                cmd.link_rd = !sts.is_newest;
            end
            lbcd_pkg::S_LK1:
            begin
                cmd.link_step1 = 1'b1;
            end
            lbcd_pkg::S_LK2:
            begin
                cmd.link_step2 = 1'b1;
            end
            lbcd_pkg::S_LK3:
            begin
                cmd.link_step3 = 1'b1;
            end
            lbcd_pkg::S_DONE:
            begin
                cmd.out_load = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/lbcd_dp.sv */
// Tag store, recency link stores and result register.
module lbcd_dp #(
    parameter int CACHE_SLOTS = lbcd_pkg::CACHE_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lbcd_pkg::FILE_W-1:0]       file_number,
    input  logic [lbcd_pkg::BLOCK_W-1:0]      block_number,
    input  logic                              fetch_ok,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lbcd_pkg::STATUS_W-1:0]     status,
    output logic [lbcd_pkg::SLOT_OUT_W-1:0]   slot_index,
    input  lbcd_pkg::dp_cmd_t                 cmd,
    output lbcd_pkg::dp_sts_t                 sts
);

    localparam int IDX_W  = $clog2(CACHE_SLOTS);
    localparam int LINK_W = $clog2(CACHE_SLOTS + 1);
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(CACHE_SLOTS);
    localparam logic [LINK_W-1:0] LAST_SLOT = LINK_W'(CACHE_SLOTS - 1);

    // Stores
    logic [lbcd_pkg::TAG_W-1:0] tag_mem   [CACHE_SLOTS];
    logic [LINK_W-1:0]          newer_mem [CACHE_SLOTS];
    logic [LINK_W-1:0]          older_mem [CACHE_SLOTS];

    // Request and working registers
    logic [lbcd_pkg::TAG_W-1:0] tag_reg;
    logic                       ok_reg;
    logic [LINK_W-1:0]          init_idx_reg;
    logic [LINK_W-1:0]          issue_idx_reg;
    logic [LINK_W-1:0]          fill_cnt_reg;
    logic [lbcd_pkg::TAG_W-1:0] tag_rd_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic                       rd_vld_reg;
    logic [IDX_W-1:0]           s_reg;
    lbcd_pkg::status_code_t     res_reg;
    logic [LINK_W-1:0]          up_reg;
    logic [LINK_W-1:0]          down_reg;
    logic [IDX_W-1:0]           newest_reg;
    logic [IDX_W-1:0]           oldest_reg;
    logic                       out_valid_reg;
    logic [lbcd_pkg::STATUS_W-1:0]   out_status_reg;
    logic [lbcd_pkg::SLOT_OUT_W-1:0] out_slot_reg;

    // Link write ports
    logic              newer_we;
    logic [IDX_W-1:0]  newer_wa;
    logic [LINK_W-1:0] newer_wd;
    logic              older_we;
    logic [IDX_W-1:0]  older_wa;
    logic [LINK_W-1:0] older_wd;
    logic              s_is_oldest;
    logic [IDX_W+lbcd_pkg::SLOT_OUT_W-1:0] s_ext;

    assign s_is_oldest = (s_reg == oldest_reg);
    assign s_ext       = {{lbcd_pkg::SLOT_OUT_W{1'b0}}, s_reg};

    // Report status
    assign sts.init_last = (init_idx_reg == LAST_SLOT);
    assign sts.hit       = rd_vld_reg && (tag_rd_reg == tag_reg);
    assign sts.more      = (issue_idx_reg < fill_cnt_reg);
    assign sts.fetch_ok  = ok_reg;
    assign sts.is_newest = (s_reg == newest_reg);
    assign sts.out_busy  = out_valid_reg && out_stall;

    // Capture the request word
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            tag_reg <= {file_number, block_number};
            ok_reg  <= fetch_ok;
        end
    end

    // Tag store: fill write and scan read
    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
        begin
            tag_mem[s_reg] <= tag_reg;
        end
        if (cmd.scan_issue)
        begin
            tag_rd_reg <= tag_mem[issue_idx_reg[IDX_W-1:0]];
            rd_idx_reg <= issue_idx_reg[IDX_W-1:0];
        end
    end

    // Scan pointer, valid read flag, fill count and init sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_idx_reg <= '0;
            rd_vld_reg    <= 1'b0;
            fill_cnt_reg  <= '0;
            init_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                issue_idx_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                issue_idx_reg <= issue_idx_reg + LINK_W'(1);
            end
            rd_vld_reg <= cmd.scan_issue;
            if (cmd.fill_wr && (fill_cnt_reg != LINK_NONE))
            begin
                fill_cnt_reg <= fill_cnt_reg + LINK_W'(1);
            end
            if (cmd.init_wr)
            begin
                init_idx_reg <= init_idx_reg + LINK_W'(1);
            end
        end
    end

    // Latch the chosen slot and result code
    always_ff @(posedge clk)
    begin
        if (cmd.set_res)
        begin
            res_reg <= cmd.res_code;
            case (cmd.res_code)
                lbcd_pkg::ST_HIT:  s_reg <= rd_idx_reg;
                lbcd_pkg::ST_FILL: s_reg <= oldest_reg;
                default:           s_reg <= '0;
            endcase
        end
    end

    // Select link store writes
    always_comb
    begin
        newer_we = 1'b0;
        newer_wa = '0;
        newer_wd = '0;
        older_we = 1'b0;
        older_wa = '0;
        older_wd = '0;
        if (cmd.init_wr)
        begin
            newer_we = 1'b1;
            newer_wa = init_idx_reg[IDX_W-1:0];
            newer_wd = init_idx_reg + LINK_W'(1);
            older_we = 1'b1;
            older_wa = init_idx_reg[IDX_W-1:0];
            older_wd = (init_idx_reg == '0) ? LINK_NONE : init_idx_reg - LINK_W'(1);
        end
        else if (cmd.link_step1)
        begin
            // Unlink the slot from its neighbours
            if (s_is_oldest)
            begin
                older_we = (up_reg != LINK_NONE);
                older_wa = up_reg[IDX_W-1:0];
                older_wd = LINK_NONE;
            end
            else
            begin
                newer_we = (down_reg != LINK_NONE);
                newer_wa = down_reg[IDX_W-1:0];
                newer_wd = up_reg;
                older_we = (up_reg != LINK_NONE);
                older_wa = up_reg[IDX_W-1:0];
                older_wd = down_reg;
            end
        end
        else if (cmd.link_step2)
        begin
            // Point the slot at the old head
            newer_we = 1'b1;
            newer_wa = s_reg;
            newer_wd = LINK_NONE;
            older_we = 1'b1;
            older_wa = s_reg;
            older_wd = LINK_W'(newest_reg);
        end
        else if (cmd.link_step3)
        begin
            // Hang the slot above the old head
            newer_we = 1'b1;
            newer_wa = newest_reg;
            newer_wd = LINK_W'(s_reg);
        end
    end

    // Link stores: one write and one read each
    always_ff @(posedge clk)
    begin
        if (newer_we)
        begin
            newer_mem[newer_wa] <= newer_wd;
        end
        if (older_we)
        begin
            older_mem[older_wa] <= older_wd;
        end
        if (cmd.link_rd)
        begin
            up_reg   <= newer_mem[s_reg];
            down_reg <= older_mem[s_reg];
        end
    end

    // Head and tail of the recency list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= IDX_W'(CACHE_SLOTS - 1);
            oldest_reg <= '0;
        end
        else
        begin
            if (cmd.link_step1 && s_is_oldest)
            begin
                oldest_reg <= up_reg[IDX_W-1:0];
            end
            if (cmd.link_step3)
            begin
                newest_reg <= s_reg;
            end
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_reg;
            out_slot_reg   <= s_ext[lbcd_pkg::SLOT_OUT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot_index = out_slot_reg;

endmodule

/* rtl/core/lru_block_cache_directory.sv */
// Top level: fully associative LRU block cache directory.
// A lookup scans the filled slots in turn; a hit or a fill then moves the slot to the head of the
// recency list unless it is already there, and a fetch error goes straight to the result.
// One lookup runs at a time; a new request is taken only once the previous result is loaded.
// After reset the link stores are swept, one slot per cycle, with the
// input stalled; tags need no clearing since only filled slots are scanned.
module lru_block_cache_directory #(
    parameter int CACHE_SLOTS = lbcd_pkg::CACHE_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lbcd_pkg::FILE_W-1:0]       file_number,
    input  logic [lbcd_pkg::BLOCK_W-1:0]      block_number,
    input  logic                              fetch_ok,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lbcd_pkg::STATUS_W-1:0]     status,
    output logic [lbcd_pkg::SLOT_OUT_W-1:0]   slot_index
);

    lbcd_pkg::dp_cmd_t cmd;
    lbcd_pkg::dp_sts_t sts;

    // Sequencer
    lbcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stores and result path
    lbcd_dp #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .file_number  (file_number),
        .block_number (block_number),
        .fetch_ok     (fetch_ok),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot_index   (slot_index),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

/* rtl/core/lbcd_checker.sv */
// Port-level checks for the LRU block cache directory, bound to the top level.
module lbcd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [lbcd_pkg::STATUS_W-1:0]     status,
    input logic [lbcd_pkg::SLOT_OUT_W-1:0]   slot_index
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Track words accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else if (in_acc && !out_acc)
        begin
            pend_reg <= pend_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_index))
        else $error("stalled result word changed");

    // Every result answers an accepted request
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pend_reg != 2'd0)
        else $error("result without request");

    // At most one lookup in flight beside a waiting result
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pend_reg < 2'd2)
        else $error("request accepted while lookup busy");

    // Fetch errors report slot zero and codes stay legal
    a_err_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == lbcd_pkg::ST_HIT || status == lbcd_pkg::ST_FILL
                       || (status == lbcd_pkg::ST_ERR && slot_index == '0)))
        else $error("bad status or slot on error");

endmodule

bind lru_block_cache_directory lbcd_checker u_lbcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .slot_index (slot_index)
);

/* sim/testbench.sv */
// Self-checking testbench for the LRU block cache directory: random and directed lookups, predicted results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbcd_pkg::*;

    localparam int NSLOTS       = CACHE_SLOTS_DEF;
    localparam int NO_LINK      = NSLOTS;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_WORDS = 900;
    localparam int TAG_POOL_MAX = 96;

    // Predicted directory: tags, fill bits and the recency chain
    class lru_directory_model;
        typedef struct {
            status_code_t            code;
            logic [SLOT_OUT_W-1:0]   slot;
        } lookup_result_t;

        logic [TAG_W-1:0] tags[NSLOTS];
        bit               filled[NSLOTS];
        int               newer[NSLOTS];
        int               older[NSLOTS];
        int               newest;
        int               oldest;
        lookup_result_t   awaited[$];
        int               mismatches;

        function new();
            for (int i = 0; i < NSLOTS; i++)
            begin
                filled[i] = 1'b0;
                newer[i]  = i + 1;
                older[i]  = (i == 0) ? NO_LINK : i - 1;
            end
            newest     = NSLOTS - 1;
            oldest     = 0;
            mismatches = 0;
        endfunction

        // Unlink a slot and put it at the most-recent end
        function void to_head(int s);
            int up;
            int down;
            if (s == newest)
                return;
            up   = newer[s];
            down = older[s];
            if (s == oldest)
            begin
                oldest = up;
                if (up < NSLOTS)
                    older[up] = NO_LINK;
            end
            else
            begin
                if (down < NSLOTS)
                    newer[down] = up;
                if (up < NSLOTS)
                    older[up] = down;
            end
            newer[s] = NO_LINK;
            older[s] = newest;
            if (newest < NSLOTS)
                newer[newest] = s;
            newest = s;
            if (oldest >= NSLOTS)
                oldest = s;
        endfunction

        // Work out the result of one accepted request and queue it
        function void note_request(logic [FILE_W-1:0] fnum, logic [BLOCK_W-1:0] bnum,
                                   logic ok);
            logic [TAG_W-1:0] key;
            lookup_result_t   r;
            int               hit_slot;
            int               victim;
            key      = {fnum, bnum};
            hit_slot = -1;
            for (int i = 0; i < NSLOTS; i++)
                if (hit_slot < 0 && filled[i] && tags[i] == key)
                    hit_slot = i;
            if (hit_slot >= 0)
            begin
                to_head(hit_slot);
                r.code = ST_HIT;
                r.slot = SLOT_OUT_W'(hit_slot);
            end
            else if (!ok || oldest >= NSLOTS)
            begin
                r.code = ST_ERR;
                r.slot = '0;
            end
            else
            begin
                victim         = oldest;
                tags[victim]   = key;
                filled[victim] = 1'b1;
                to_head(victim);
                r.code = ST_FILL;
                r.slot = SLOT_OUT_W'(victim);
            end
            awaited.push_back(r);
        endfunction

        // Compare an accepted result word with the oldest prediction
        function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_OUT_W-1:0] slot);
            lookup_result_t r;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d slot %0d", st, slot);
                return;
            end
            r = awaited.pop_front();
            if (st !== r.code || slot !== r.slot)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status expected %0d got %0d, slot expected %0d got %0d",
                             r.code, st, r.slot, slot);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [FILE_W-1:0]     file_number  = '0;
    logic [BLOCK_W-1:0]    block_number = '0;
    logic                  fetch_ok     = 1'b0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_index;

    lru_directory_model    dir_model = new();
    int                    idle_cycles   = 0;
    bit                    sender_quiet  = 1'b0;
    logic [TAG_W-1:0]      tag_pool[$];

    lru_block_cache_directory DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .file_number  (file_number),
        .block_number (block_number),
        .fetch_ok     (fetch_ok),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot_index   (slot_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hold reset, then release it
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Gap lengths: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (sender_quiet || $urandom_range(0, 99) < 45)
            return 0;
        return idle_len();
    endfunction

    // Present one request word and hold it until accepted
    task automatic send_request(input logic [FILE_W-1:0] fnum, input logic [BLOCK_W-1:0] bnum,
                                input logic ok);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        file_number  <= fnum;
        block_number <= bnum;
        fetch_ok     <= ok;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (dir_model.outstanding() != 0);
    endtask

    // Note accepted requests, check accepted results, count quiet cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                dir_model.note_request(file_number, block_number, fetch_ok);
            if (out_valid && !out_stall)
                dir_model.check_result(status, slot_index);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Stall the result side in bursts, with stretches of none
    initial
    begin
        int hold_left;
        int cycle_no;
        bit stall_on;
        hold_left = 0;
        cycle_no  = 0;
        stall_on  = 1'b1;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no % 400 == 0)
                stall_on = ($urandom_range(0, 2) != 0);
            if (hold_left == 0 && stall_on && $urandom_range(0, 3) == 0)
                hold_left = idle_len();
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // End the run when nothing moves for too long
    initial
    begin
        do
            @(posedge clk);
        while (idle_cycles < IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Stimulus: directed lookups, then random traffic over a rolling set of tags
    initial
    begin
        logic [TAG_W-1:0] key;
        logic             ok;
        int               pick;
        wait (rst_n);
        @(posedge clk);

        // Empty directory: a zero tag must not match unwritten slots
        send_request('0, '0, 1'b0);
        send_request('0, '0, 1'b1);
        send_request('1, '1, 1'b1);
        // Hit on the newest slot, then on the oldest
        send_request('1, '1, 1'b0);
        send_request('0, '0, 1'b0);
        send_request(16'hFFFF, '0, 1'b1);
        send_request('0, 31'h7FFF_FFFF, 1'b1);
        send_request(16'h5555, 31'h2AAA_AAAA, 1'b1);
        send_request(16'hAAAA, 31'h5555_5555, 1'b1);
        // Hits in the middle of the chain
        send_request(16'hFFFF, '0, 1'b0);
        send_request(16'hAAAA, 31'h5555_5555, 1'b1);
        // Failed fetch while slots are filled
        send_request(16'h1234, 31'h00AB_CDEF, 1'b0);
        send_request('1, '1, 1'b1);
        send_request('0, 31'h7FFF_FFFF, 1'b0);
        wait_for_results();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
                sender_quiet = ($urandom_range(0, 3) == 0);
            if (n % 300 == 150)
                wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 30 && tag_pool.size() > 16)
                key = tag_pool[$urandom_range(tag_pool.size() - 16, tag_pool.size() - 1)];
            else if (pick < 50 && tag_pool.size() > 0)
                key = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
            else if (pick < 85)
                key = {16'($urandom_range(0, 3)), 31'($urandom_range(0, 4095))};
            else
                key = {16'($urandom), 31'($urandom)};
            ok = ($urandom_range(0, 9) != 0);
            send_request(key[TAG_W-1:BLOCK_W], key[BLOCK_W-1:0], ok);
            tag_pool.push_back(key);
            if (tag_pool.size() > TAG_POOL_MAX)
                void'(tag_pool.pop_front());
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (dir_model.mismatches == 0 && dir_model.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
